FILE: hdl/lpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_pkg: shared types and constants of the lidar point colorizer
// Fixed-point widths, store size, command, status and register codes.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = 20;
    localparam int MAX_PIXELS  = 1 << ADDR_W;
    localparam int PROD_W      = 64;              // 32 x 32 signed product
    localparam int SUM_W       = PROD_W + 2;      // four products summed
    localparam int Q_W         = 15;              // magnitude bits of u and v
    localparam int DIV_W       = SUM_W + Q_W;     // room for divisor << 15
    localparam int DIM_W       = 13;
    localparam int AREA_W      = 2 * DIM_W;
    localparam int VW_W        = 16 + DIM_W + 1;  // v * width
    localparam int IDX_W       = VW_W + 1;        // v * width + u

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    localparam logic [1:0] ST_COLORED = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;
    localparam logic [1:0] ST_BLACK   = 2'd3;

    localparam logic [2:0] REG_ROW0_A = 3'd0;
    localparam logic [2:0] REG_ROW0_B = 3'd1;
    localparam logic [2:0] REG_ROW1_A = 3'd2;
    localparam logic [2:0] REG_ROW1_B = 3'd3;
    localparam logic [2:0] REG_ROW2_A = 3'd4;
    localparam logic [2:0] REG_ROW2_B = 3'd5;
    localparam logic [2:0] REG_WIDTH  = 3'd6;
    localparam logic [2:0] REG_HEIGHT = 3'd7;

    typedef struct packed {
        logic              valid;
        logic              cmd;
        logic [ADDR_W-1:0] pix_addr;
        logic [23:0]       pix_rgb;
        logic              zero_pt;
    } ctl_t;

    typedef struct packed {
        ctl_t             ctl;
        logic             bad_depth;
        logic [SUM_W-1:0] den;
        logic [DIV_W-1:0] rem_u;
        logic [DIV_W-1:0] rem_v;
        logic             neg_u;
        logic             neg_v;
        logic             sat_u;
        logic             sat_v;
        logic [Q_W-1:0]   q_u;
        logic [Q_W-1:0]   q_v;
    } div_t;

endpackage
`default_nettype wire

FILE: hdl/lidar_point_colorizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_point_colorizer: pinhole projection of lidar points onto a stored image
// Pixel words fill a 1M x 24 image store; point words are projected through
// a 3x4 Q16.16 matrix, divided by depth and looked up in the store.
// ----------------------------------------------------------------------------
//  port group         direction  handshake          payload
//  command word       in         start / busy       command, pixel_index,
//                                                   red_in..blue_in, point_x..z
//  result word        out        done (strobe)      status, pixel_u, pixel_v,
//                                                   red_out..blue_out
//  register write     in         wr_en              wr_index, wr_data
//
//  One word is taken every cycle; busy is never raised.
//  A point word passes, in order, the stages products (1), sums (2), depth
//  division (16: a setup and saturation check, then one quotient bit per stage),
//  index (2), store read (1) and output (1). Pixel words give no result.
//  Pixel writes and point reads hit the store at the same stage, so they
//  act in the order taken. The store is not cleared by reset.
//  The receiver cannot stall; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module lidar_point_colorizer
    import lpc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 command,
    input  wire logic [ADDR_W-1:0]    pixel_index,
    input  wire logic [7:0]           red_in,
    input  wire logic [7:0]           green_in,
    input  wire logic [7:0]           blue_in,
    input  wire logic signed [31:0]   point_x,
    input  wire logic signed [31:0]   point_y,
    input  wire logic signed [31:0]   point_z,
    output logic                      done,
    output logic [1:0]                status,
    output logic signed [15:0]        pixel_u,
    output logic signed [15:0]        pixel_v,
    output logic [7:0]                red_out,
    output logic [7:0]                green_out,
    output logic [7:0]                blue_out,
    input  wire logic                 wr_en,
    input  wire logic [2:0]           wr_index,
    input  wire logic [63:0]          wr_data
);

    // ---------------- configuration registers ----------------
    logic [63:0]       proj_reg [0:5];
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [AREA_W-1:0] area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                proj_reg[i] <= '0;
            end
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ROW0_A: proj_reg[0] <= wr_data;
                REG_ROW0_B: proj_reg[1] <= wr_data;
                REG_ROW1_A: proj_reg[2] <= wr_data;
                REG_ROW1_B: proj_reg[3] <= wr_data;
                REG_ROW2_A: proj_reg[4] <= wr_data;
                REG_ROW2_B: proj_reg[5] <= wr_data;
                REG_WIDTH:  width_reg   <= wr_data[DIM_W-1:0];
                REG_HEIGHT: height_reg  <= wr_data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // image size, recomputed every cycle; user must change registers only when idle, unenforced
    always_ff @(posedge clk)
    begin
        area_reg <= width_reg * height_reg;
    end

    assign busy = 1'b0;

    // ---------------- stage P: twelve products ----------------
    ctl_t                     ctl_in;
    ctl_t                     p_ctl_reg;
    logic signed [PROD_W-1:0] prod_reg  [0:11];
    logic signed [PROD_W-1:0] prod_next [0:11];

    always_comb
    begin
        ctl_in.valid    = start;
        ctl_in.cmd      = command;
        ctl_in.pix_addr = pixel_index;
        ctl_in.pix_rgb  = {red_in, green_in, blue_in};
        ctl_in.zero_pt  = (point_x == '0) && (point_y == '0) && (point_z == '0);
        for (int r = 0; r < 3; r++)
        begin
            prod_next[4*r]     = $signed(proj_reg[2*r][31:0])    * point_x;
            prod_next[4*r + 1] = $signed(proj_reg[2*r][63:32])   * point_y;
            prod_next[4*r + 2] = $signed(proj_reg[2*r+1][31:0])  * point_z;
            // constant term: coefficient times one in fixed point
            prod_next[4*r + 3] = {{(PROD_W-32-FRAC_BITS){proj_reg[2*r+1][63]}},
                                  proj_reg[2*r+1][63:32], {FRAC_BITS{1'b0}}};
        end
    end

    // ---------------- stage S1: pair sums ----------------
    ctl_t                      s1_ctl_reg;
    logic signed [PROD_W:0]    half_reg [0:5];

    // ---------------- stage S2: row sums ----------------
    ctl_t                      s2_ctl_reg;
    logic signed [SUM_W-1:0]   num_u_reg;
    logic signed [SUM_W-1:0]   num_v_reg;
    logic signed [SUM_W-1:0]   den_reg;

    // ---------------- divider stages ----------------
    div_t div_reg  [0:Q_W];
    div_t div_next [0:Q_W];

    always_comb
    begin
        logic [SUM_W-1:0] mag_u;
        logic [SUM_W-1:0] mag_v;
        logic [DIV_W-1:0] dsh;
        logic [DIV_W-1:0] dt;

        mag_u = num_u_reg[SUM_W-1] ? SUM_W'(-num_u_reg) : num_u_reg;
        mag_v = num_v_reg[SUM_W-1] ? SUM_W'(-num_v_reg) : num_v_reg;
        dsh   = {{Q_W{1'b0}}, den_reg} << Q_W;

        div_next[0].ctl       = s2_ctl_reg;
        div_next[0].bad_depth = den_reg[SUM_W-1] || (den_reg == '0);
        div_next[0].den       = den_reg;
        div_next[0].rem_u     = {{Q_W{1'b0}}, mag_u};
        div_next[0].rem_v     = {{Q_W{1'b0}}, mag_v};
        div_next[0].neg_u     = num_u_reg[SUM_W-1];
        div_next[0].neg_v     = num_v_reg[SUM_W-1];
        div_next[0].sat_u     = {{Q_W{1'b0}}, mag_u} >= dsh;
        div_next[0].sat_v     = {{Q_W{1'b0}}, mag_v} >= dsh;
        div_next[0].q_u       = '0;
        div_next[0].q_v       = '0;

        // one restoring step per stage, quotient bit Q_W-k
        for (int k = 1; k <= Q_W; k++)
        begin
            div_next[k] = div_reg[k-1];
            dt = {{Q_W{1'b0}}, div_reg[k-1].den} << (Q_W - k);
            if (div_reg[k-1].rem_u >= dt)
            begin
                div_next[k].rem_u         = div_reg[k-1].rem_u - dt;
                div_next[k].q_u[Q_W - k]  = 1'b1;
            end
            if (div_reg[k-1].rem_v >= dt)
            begin
                div_next[k].rem_v         = div_reg[k-1].rem_v - dt;
                div_next[k].q_v[Q_W - k]  = 1'b1;
            end
        end
    end

    // ---------------- stage I1: quotients and v * width ----------------
    ctl_t                    i1_ctl_reg;
    logic                    i1_bad_reg;
    logic signed [15:0]      i1_u_reg;
    logic signed [15:0]      i1_v_reg;
    logic signed [VW_W-1:0]  i1_vw_reg;
    logic signed [15:0]      u_next;
    logic signed [15:0]      v_next;
    logic                    bad_next;

    always_comb
    begin
        div_t dl;
        dl = div_reg[Q_W];
        bad_next = dl.bad_depth || dl.ctl.zero_pt;
        if (dl.sat_u)
            u_next = dl.neg_u ? 16'sh8000 : 16'sh7FFF;
        else
            u_next = dl.neg_u ? -$signed({1'b0, dl.q_u}) : $signed({1'b0, dl.q_u});
        if (dl.sat_v)
            v_next = dl.neg_v ? 16'sh8000 : 16'sh7FFF;
        else
            v_next = dl.neg_v ? -$signed({1'b0, dl.q_v}) : $signed({1'b0, dl.q_v});
        if (bad_next)
        begin
            u_next = '0;
            v_next = '0;
        end
    end

    // ---------------- stage I2: index and bounds ----------------
    ctl_t                i2_ctl_reg;
    logic                i2_bad_reg;
    logic                i2_in_reg;
    logic [ADDR_W-1:0]   i2_addr_reg;
    logic signed [15:0]  i2_u_reg;
    logic signed [15:0]  i2_v_reg;
    logic signed [IDX_W-1:0] idx_next;

    assign idx_next = IDX_W'(i1_vw_reg) + IDX_W'(i1_u_reg);

    // ---------------- stage M: store access ----------------
    ctl_t                m_ctl_reg;
    logic [1:0]          m_pre_reg;
    logic signed [15:0]  m_u_reg;
    logic signed [15:0]  m_v_reg;
    logic [23:0]         rd_reg;
    logic [23:0]         store [0:MAX_PIXELS-1];

    always_ff @(posedge clk)
    begin
        if (i2_ctl_reg.valid && i2_ctl_reg.cmd == CMD_WRITE &&
            {1'b0, i2_ctl_reg.pix_addr} < (ADDR_W+1)'(MAX_PIXELS))
        begin
            store[i2_ctl_reg.pix_addr] <= i2_ctl_reg.pix_rgb;
        end
        rd_reg <= store[i2_addr_reg];
    end

    // ---------------- output stage ----------------
    logic                done_reg;
    logic [1:0]          status_reg;
    logic signed [15:0]  u_reg;
    logic signed [15:0]  v_reg;
    logic [23:0]         rgb_reg;
    logic [1:0]          status_next;
    logic [23:0]         rgb_next;

    always_comb
    begin
        rgb_next    = '0;
        status_next = m_pre_reg;
        if (m_pre_reg == ST_COLORED)
        begin
            if (rd_reg == '0)
                status_next = ST_BLACK;
            else
                rgb_next = rd_reg;
        end
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_ctl_reg  <= '0;
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            for (int k = 0; k <= Q_W; k++)
            begin
                div_reg[k] <= '0;
            end
            i1_ctl_reg <= '0;
            i2_ctl_reg <= '0;
            m_ctl_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            p_ctl_reg  <= ctl_in;
            s1_ctl_reg <= p_ctl_reg;
            s2_ctl_reg <= s1_ctl_reg;
            for (int k = 0; k <= Q_W; k++)
            begin
                div_reg[k] <= div_next[k];
            end
            i1_ctl_reg <= div_reg[Q_W].ctl;
            i2_ctl_reg <= i1_ctl_reg;
            m_ctl_reg  <= i2_ctl_reg;
            done_reg   <= m_ctl_reg.valid && m_ctl_reg.cmd == CMD_POINT;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 12; i++)
        begin
            prod_reg[i] <= prod_next[i];
        end
        for (int r = 0; r < 3; r++)
        begin
            half_reg[2*r]     <= $signed({prod_reg[4*r][PROD_W-1], prod_reg[4*r]})
                                 + $signed({prod_reg[4*r+1][PROD_W-1], prod_reg[4*r+1]});
            half_reg[2*r + 1] <= $signed({prod_reg[4*r+2][PROD_W-1], prod_reg[4*r+2]})
                                 + $signed({prod_reg[4*r+3][PROD_W-1], prod_reg[4*r+3]});
        end
        num_u_reg <= $signed({half_reg[0][PROD_W], half_reg[0]})
                     + $signed({half_reg[1][PROD_W], half_reg[1]});
        num_v_reg <= $signed({half_reg[2][PROD_W], half_reg[2]})
                     + $signed({half_reg[3][PROD_W], half_reg[3]});
        den_reg   <= $signed({half_reg[4][PROD_W], half_reg[4]})
                     + $signed({half_reg[5][PROD_W], half_reg[5]});
        i1_bad_reg  <= bad_next;
        i1_u_reg    <= u_next;
        i1_v_reg    <= v_next;
        i1_vw_reg   <= v_next * $signed({1'b0, width_reg});
        i2_bad_reg  <= i1_bad_reg;
        i2_u_reg    <= i1_u_reg;
        i2_v_reg    <= i1_v_reg;
        i2_addr_reg <= idx_next[ADDR_W-1:0];
        i2_in_reg   <= !idx_next[IDX_W-1]
                       && (idx_next < $signed({{(IDX_W-AREA_W){1'b0}}, area_reg}))
                       && (idx_next < IDX_W'(MAX_PIXELS));
        m_u_reg     <= i2_u_reg;
        m_v_reg     <= i2_v_reg;
        if (i2_ctl_reg.zero_pt)
            m_pre_reg <= ST_ZERO;
        else if (i2_bad_reg || !i2_in_reg)
            m_pre_reg <= ST_OUTSIDE;
        else
            m_pre_reg <= ST_COLORED;
        status_reg  <= status_next;
        u_reg       <= m_u_reg;
        v_reg       <= m_v_reg;
        rgb_reg     <= rgb_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign pixel_u   = u_reg;
    assign pixel_v   = v_reg;
    assign red_out   = rgb_reg[23:16];
    assign green_out = rgb_reg[15:8];
    assign blue_out  = rgb_reg[7:0];

`ifndef ASSERT_OFF
    // a result only ever follows a point word taken earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && command == CMD_POINT, 23))
        else $error("result without matching point word");

    // colour only shown when colored
    a_colour: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_COLORED |-> rgb_reg == '0)
        else $error("colour on non-colored result");

    // zero point carries no projection
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_ZERO |-> pixel_u == '0 && pixel_v == '0)
        else $error("zero point with projection");

    // colored result has a non-black colour
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_COLORED |-> rgb_reg != '0)
        else $error("black pixel reported as colored");
`endif

endmodule
`default_nettype wire
